// File: rtl/core/olkd_pkg.sv
// shared types and constants for the ordered list with key delete
package olkd_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // request codes
  localparam logic [1:0] REQ_INSERT     = 2'd0;
  localparam logic [1:0] REQ_DEL_FRONT  = 2'd1;
  localparam logic [1:0] REQ_DEL_BACK   = 2'd2;
  localparam logic [1:0] REQ_DEL_KEY    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // input beat
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
  } req_t;

  // output beat
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         entry_count;
  } rsp_t;

  // hand-off between neighboring cells, head toward tail
  typedef struct packed {
    logic  found;
    data_t rem;
  } link_t;

endpackage

// File: rtl/core/olkd_cell.sv
// one list slot: holds an entry, finds the hit and shifts toward the head
module olkd_cell (
  input  logic                clk,
  input  logic                en,
  input  logic [1:0]          op,
  input  olkd_pkg::data_t     key,
  input  logic                occ,
  input  logic                prev_occ,
  input  logic                next_occ,
  input  olkd_pkg::data_t     next_entry,
  input  olkd_pkg::link_t     link_in,
  output olkd_pkg::link_t     link_out,
  output olkd_pkg::data_t     entry
);
  import olkd_pkg::*;

  logic hit_raw;
  logic first;

  // does this slot qualify for removal under the current request
  always_comb begin
    unique case (op)
      REQ_INSERT:    hit_raw = 1'b0;
      REQ_DEL_FRONT: hit_raw = occ;
      REQ_DEL_BACK:  hit_raw = occ & ~next_occ;
      REQ_DEL_KEY:   hit_raw = occ & (entry == key);
      default:       hit_raw = 1'b0;
    endcase
  end

  // first hit from the head claims the removal
  assign first          = hit_raw & ~link_in.found;
  assign link_out.found = link_in.found | hit_raw;
  assign link_out.rem   = first ? entry : link_in.rem;

  // append at the first free slot, or close the gap behind the removed slot
  always_ff @(posedge clk) begin
    if (en) begin
      if (op == REQ_INSERT) begin
        if (!occ && prev_occ) begin
          entry <= key;
        end
      end else if (link_out.found) begin
        entry <= next_entry;
      end
    end
  end

endmodule

// File: rtl/core/ordered_list_with_key_delete_top.sv
// top level: request register, chain of list cells, count and result register
//
// Holds up to DEPTH entries in order from head to tail and serves insert at
// tail, delete front, delete back and delete by key (first match from the
// head, later entries move up). Each request beat yields one result beat with
// status, removed value and the new count. A request is registered on
// acceptance and executed once the result register is free, and
// throughput is one request per cycle while the result side keeps up.
// The cycle time is set by the match and removed-value chain that runs
// through all DEPTH cells in the execute cycle.
module ordered_list_with_key_delete_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  olkd_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output olkd_pkg::rsp_t out_data
);
  import olkd_pkg::*;

  logic  pend_valid;
  req_t  pend;
  logic  exec;
  cnt_t  count;
  cnt_t  count_next;
  logic [1:0] status_next;
  data_t      rem_next;
  data_t      key;

  logic  [DEPTH-1:0] occ;
  data_t             entry [DEPTH];
  link_t             link  [DEPTH+1];

  // execute when a request waits and the result register is free
  assign exec     = pend_valid && (!out_valid || out_ready);
  assign in_ready = !pend_valid || exec;
  assign key      = DATA_WIDTH'($unsigned(pend.value));

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_ready) begin
      pend_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      pend <= in_data;
    end
  end

  assign link[0].found = 1'b0;
  assign link[0].rem   = '0;

  // the cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  prev_o;
    logic  next_o;
    data_t next_e;

    assign occ[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_o = 1'b1;
    end else begin : g_mid
      assign prev_o = occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_o = 1'b0;
      assign next_e = key;
    end else begin : g_body
      assign next_o = (count > CNT_W'(i + 1));
      assign next_e = entry[i+1];
    end

    olkd_cell u_cell (
      .clk        (clk),
      .en         (exec),
      .op         (pend.req_type),
      .key        (key),
      .occ        (occ[i]),
      .prev_occ   (prev_o),
      .next_occ   (next_o),
      .next_entry (next_e),
      .link_in    (link[i]),
      .link_out   (link[i+1]),
      .entry      (entry[i])
    );
  end

  // status, removed value and new count
  always_comb begin
    status_next = ST_OK;
    rem_next    = '0;
    count_next  = count;
    if (pend.req_type == REQ_INSERT) begin
      if (count == CNT_W'(DEPTH)) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else if (count == '0) begin
      status_next = ST_EMPTY;
    end else if (!link[DEPTH].found) begin
      status_next = ST_NOT_FOUND;
    end else begin
      rem_next   = link[DEPTH].rem;
      count_next = count - CNT_W'(1);
    end
  end

  // count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (exec) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (exec) begin
      out_data.status        <= status_next;
      out_data.removed_value <= 32'(rem_next);
      out_data.entry_count   <= 5'(count_next);
    end
  end

endmodule

// File: tb/ordered_list_with_key_delete_top_tb.sv
// testbench for the ordered list with key delete: directed and random requests, checked beat by beat
`timescale 1ns / 1ps

module ordered_list_with_key_delete_top_tb;
  import olkd_pkg::*;

  localparam int RANDOM_REQS = 600;
  localparam int CALM_TAIL   = 60;
  localparam int DRAIN_WAIT  = 8;

  // one queued request, or a marker that holds the sender until all results are back
  typedef struct {
    bit   hold;
    req_t req;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  pending_t pending_reqs[$];
  rsp_t     rsp_expect[$];
  int       fail_count = 0;
  logic     calm = 1'b0;
  int       send_gap = 0;
  int       recv_stall = 0;

  // shadow copy of the list contents
  data_t list_store[DEPTH];
  int    list_count = 0;

  ordered_list_with_key_delete_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // remove one entry, later entries move up toward the head
  function automatic data_t take_entry(int pos);
    data_t v;
    v = list_store[pos];
    for (int i = pos; i + 1 < list_count; i++) list_store[i] = list_store[i + 1];
    list_count--;
    return v;
  endfunction

  // apply one request to the shadow list and return the result it should give
  function automatic rsp_t apply_request(req_t r);
    rsp_t  res;
    data_t key;
    int    hit;
    res = '0;
    res.status = ST_OK;
    key = data_t'(r.value);
    hit = -1;
    case (r.req_type)
      REQ_INSERT: begin
        if (list_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_store[list_count] = key;
          list_count++;
        end
      end
      REQ_DEL_FRONT: begin
        if (list_count == 0) res.status = ST_EMPTY;
        else res.removed_value = take_entry(0);
      end
      REQ_DEL_BACK: begin
        if (list_count == 0) res.status = ST_EMPTY;
        else res.removed_value = take_entry(list_count - 1);
      end
      default: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // first match counted from the head
          for (int i = 0; i < list_count; i++) begin
            if (hit < 0 && list_store[i] == key) hit = i;
          end
          if (hit < 0) res.status = ST_NOT_FOUND;
          else res.removed_value = take_entry(hit);
        end
      end
    endcase
    res.entry_count = 5'(list_count);
    return res;
  endfunction

  task automatic push_req(logic [1:0] kind, logic [31:0] val);
    pending_t p;
    p.hold = 1'b0;
    p.req.req_type = kind;
    p.req.value = val;
    pending_reqs.push_back(p);
  endtask

  task automatic push_hold();
    pending_t p;
    p.hold = 1'b1;
    p.req = '0;
    pending_reqs.push_back(p);
  endtask

  // request driver: predicts at acceptance, then presents the next beat or idles
  always @(posedge clk) begin
    pending_t nxt;
    logic     v_next;
    req_t     d_next;
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap = 0;
    end else begin
      v_next = in_valid;
      d_next = in_data;
      if (in_valid && in_ready) begin
        rsp_expect.push_back(apply_request(in_data));
        v_next = 1'b0;
      end
      if (!v_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          if (pending_reqs[0].hold) begin
            if (rsp_expect.size() == 0) void'(pending_reqs.pop_front());
          end else if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 16) - 1;
          end else begin
            nxt = pending_reqs.pop_front();
            v_next = 1'b1;
            d_next = nxt.req;
          end
        end
      end
      in_valid <= v_next;
      in_data  <= d_next;
      calm     <= (pending_reqs.size() < CALM_TAIL);
    end
  end

  // result monitor: compare each beat with the oldest expectation, stall at random
  always @(posedge clk) begin
    rsp_t want;
    logic r_next;
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (rsp_expect.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_count++;
        end else begin
          want = rsp_expect.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d",
                   want.removed_value, out_data.removed_value);
            fail_count++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   want.entry_count, out_data.entry_count);
            fail_count++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        r_next = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(1, 16) - 1;
        r_next = 1'b0;
      end else begin
        r_next = 1'b1;
      end
      out_ready <= r_next;
    end
  end

  // stimulus and end of run
  initial begin
    logic [31:0] value_pool[8];
    logic [1:0]  kind;
    logic [31:0] val;
    int          made;
    int          seg_len;
    int          fill_pct;

    // deletes of every kind on an empty list
    push_req(REQ_DEL_FRONT, 32'h0000_0000);
    push_req(REQ_DEL_BACK, 32'hFFFF_FFFF);
    push_req(REQ_DEL_KEY, 32'h0000_0000);
    // extremes and a duplicate key
    push_req(REQ_INSERT, 32'h7FFF_FFFF);
    push_req(REQ_INSERT, 32'h8000_0000);
    push_req(REQ_INSERT, 32'h0000_0005);
    push_req(REQ_INSERT, 32'hFFFF_FFFF);
    push_req(REQ_INSERT, 32'h0000_0005);
    push_req(REQ_INSERT, 32'h0000_0000);
    // only the match nearest the head goes
    push_req(REQ_DEL_KEY, 32'h0000_0005);
    // key absent
    push_req(REQ_DEL_KEY, 32'h0001_2345);
    push_req(REQ_DEL_FRONT, 32'h0000_0000);
    push_req(REQ_DEL_BACK, 32'h0000_0000);
    // fill to the top, then an insert that is dropped
    for (int i = 0; i < DEPTH - 3; i++) push_req(REQ_INSERT, $urandom);
    push_req(REQ_INSERT, 32'hDEAD_BEEF);
    push_req(REQ_DEL_KEY, 32'h8000_0000);
    push_hold();

    // small pool of keys so that delete by key often hits
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    // random segments that lean toward filling or toward draining
    made = 0;
    while (made < RANDOM_REQS) begin
      seg_len = $urandom_range(8, 40);
      fill_pct = ($urandom_range(0, 1) == 1) ? 75 : 30;
      for (int k = 0; k < seg_len && made < RANDOM_REQS; k++) begin
        if ($urandom_range(1, 100) <= fill_pct) begin
          kind = REQ_INSERT;
        end else begin
          case ($urandom_range(0, 2))
            0:       kind = REQ_DEL_FRONT;
            1:       kind = REQ_DEL_BACK;
            default: kind = REQ_DEL_KEY;
          endcase
        end
        if ($urandom_range(0, 3) == 0) val = $urandom;
        else val = value_pool[$urandom_range(0, 7)];
        push_req(kind, val);
        made++;
        if (made == RANDOM_REQS / 2) push_hold();
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // all requests accepted, then all results back, then a short settle
    do @(posedge clk); while (pending_reqs.size() > 0 || in_valid);
    do @(posedge clk); while (rsp_expect.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("** ordered_list_with_key_delete_top: PASSED **");
    end else begin
      $display("** ordered_list_with_key_delete_top: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("** ordered_list_with_key_delete_top: FAILED **");
    $finish;
  end

endmodule
